// ===== rtl/tets_pkg.sv =====
package tets_pkg;

  localparam int NUM_LISTS  = 32;
  localparam int LIST_DEPTH = 64;
  localparam int MAX_VALUES = 5;

  // Number of value fields carried on the ports.
  localparam int NUM_SLOTS  = 5;
  localparam int WORD_W     = 32;

  localparam int LIST_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int ADDR_W  = LIST_W + IDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] TM_ANY      = 3'd0;
  localparam logic [2:0] TM_EQUAL    = 3'd1;
  localparam logic [2:0] TM_AT_AFTER = 3'd2;
  localparam logic [2:0] TM_AFTER    = 3'd3;
  localparam logic [2:0] TM_BEFORE   = 3'd4;
  localparam logic [2:0] TM_AT_BEFORE = 3'd5;

  localparam logic [1:0] DM_IGNORE = 2'd0;
  localparam logic [1:0] DM_EQUAL  = 2'd1;
  localparam logic [1:0] DM_DIFFER = 2'd2;

  localparam logic [2:0] ONE_VALUE  = 3'd1;
  localparam logic [2:0] WIDE_COUNT = 3'(MAX_VALUES);

  typedef struct packed {
    logic [1:0]                          operation;
    logic [4:0]                          list_id;
    logic signed [WORD_W-1:0]            time_value;
    logic [NUM_SLOTS-1:0][WORD_W-1:0]    values;
    logic [2:0]                          time_mode;
    logic [1:0]                          data_mode;
    logic                                search_backward;
  } item_t;

  typedef struct packed {
    logic                                found;
    logic [2:0]                          value_count;
    logic signed [WORD_W-1:0]            match_time;
    logic [NUM_SLOTS-1:0][WORD_W-1:0]    values;
    logic                                list_full;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic append;
    logic clear;
    logic scan_start;
    logic scan_en;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_append;
    logic is_clear;
    logic hit;
    logic scan_done;
  } sts_t;

endpackage

// ===== rtl/timed_event_table_search_top.sv =====
// An item is accepted only while the controller is idle and is captured; an append or clear
// then updates the list and loads the result register, and a query starts a scan that steps
// through one event per cycle over the event memory's single read port until a match or the
// end of the list, and then loads the result register. A result still waiting for its
// transaction stalls the next item, which is accepted but not started. Reset (rst_n low, synchronous) empties
// every list and clears the wide list mask; the event memories are not cleared.
module timed_event_table_search_top (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: wide_list_mask write.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, from bit 0: list_id[4:0], time_value[36:5], in_value0[68:37],
  // in_value1[100:69], in_value2[132:101], in_value3[164:133],
  // in_value4[196:165], time_mode[199:197], data_mode[201:200],
  // search_backward[202], zero padding[207:203].
  input  logic [207:0] in_tdata,
  // in_tuser: operation[1:0].
  input  logic [1:0]   in_tuser,
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, from bit 0: found[0], value_count[3:1], match_time[35:4],
  // out_value0[67:36], out_value1[99:68], out_value2[131:100],
  // out_value3[163:132], out_value4[195:164], list_full[196],
  // zero padding[199:197].
  output logic [199:0] out_tdata
);
  import tets_pkg::*;

  item_t   item;
  result_t res;
  cmd_t    cmd;
  sts_t    sts;

  // The mask register can always take a write transaction.
  assign cfg_ready = 1'b1;

  // Unpack the input transaction into the item fields.
  assign item.operation       = in_tuser;
  assign item.list_id         = in_tdata[4:0];
  assign item.time_value      = in_tdata[36:5];
  assign item.values[0]       = in_tdata[68:37];
  assign item.values[1]       = in_tdata[100:69];
  assign item.values[2]       = in_tdata[132:101];
  assign item.values[3]       = in_tdata[164:133];
  assign item.values[4]       = in_tdata[196:165];
  assign item.time_mode       = in_tdata[199:197];
  assign item.data_mode       = in_tdata[201:200];
  assign item.search_backward = in_tdata[202];

  // The controller sequences each item: it captures the item, runs the
  // append, clear or scan, and loads the result register, which then waits
  // for the output transaction while the next item is already accepted.
  tets_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the per-list counts, the mask, the event memories,
  // the scan counters and the match logic.
  tets_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .item_i   (item),
    .cmd      (cmd),
    .sts      (sts),
    .res_o    (res)
  );

  assign out_tdata = {3'b000, res.list_full, res.values[4], res.values[3],
                      res.values[2], res.values[1], res.values[0],
                      res.match_time, res.value_count, res.found};

`ifndef SYNTHESIS
  // A match always reports the list's value count.
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.found |-> res.value_count == ONE_VALUE ||
                               res.value_count == WIDE_COUNT)
    else $error("found result with a bad value count");

  // A dropped append and a match cannot be reported by the same item.
  a_full_vs_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res.found && res.list_full))
    else $error("list_full and found set together");

  // Without a match, time and count read as zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.found |-> res.match_time == 0 && res.value_count == 0)
    else $error("miss result carries time or count");

  // The engine works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in progress");
`endif

endmodule

// ===== rtl/tets_dp.sv =====
module tets_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [31:0]     cfg_data,
  input  tets_pkg::item_t item_i,
  input  tets_pkg::cmd_t  cmd,
  output tets_pkg::sts_t  sts,
  output tets_pkg::result_t res_o
);
  import tets_pkg::*;

  typedef logic [MAX_VALUES-1:0][WORD_W-1:0] row_t;

  logic [31:0]          mask_r;
  logic [CNT_W-1:0]     count_r [NUM_LISTS];
  item_t                item_r;
  result_t              out_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     step_r;
  logic                 rd_valid_r;
  logic [WORD_W-1:0]    rd_time_r;
  row_t                 rd_vals_r;

  logic [WORD_W-1:0]    time_mem [MEM_DEPTH];
  row_t                 val_mem  [MEM_DEPTH];

  logic                 list_ok;
  logic [LIST_W-1:0]    lidx;
  logic [CNT_W-1:0]     cnt_cur;
  logic                 full;
  logic                 do_write;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    rd_addr;
  logic [CNT_W-1:0]     idx_full;
  logic                 issue_done;
  logic                 issue;
  logic                 time_ok;
  logic                 data_ok;
  logic                 hit;
  logic                 wide;
  logic [2:0]           nvals;
  row_t                 wr_row;
  result_t              res_nxt;

  assign list_ok  = 32'(item_r.list_id) < NUM_LISTS;
  assign lidx     = item_r.list_id[LIST_W-1:0];
  assign cnt_cur  = count_r[lidx];
  assign full     = cnt_cur >= CNT_W'(LIST_DEPTH);
  assign do_write = cmd.append && list_ok && !full;
  assign wr_addr  = {lidx, cnt_cur[IDX_W-1:0]};

  assign issue_done = step_r >= n_r;
  assign issue      = cmd.scan_en && !issue_done && !hit;
  assign idx_full   = item_r.search_backward ? (n_r - step_r - CNT_W'(1)) : step_r;
  assign rd_addr    = {lidx, idx_full[IDX_W-1:0]};

  always_comb begin
    for (int k = 0; k < MAX_VALUES; k++) begin
      wr_row[k] = item_r.values[k];
    end
  end

  always_comb begin
    unique case (item_r.time_mode)
      TM_ANY:       time_ok = 1'b1;
      TM_EQUAL:     time_ok = $signed(rd_time_r) == item_r.time_value;
      TM_AT_AFTER:  time_ok = $signed(rd_time_r) >= item_r.time_value;
      TM_AFTER:     time_ok = $signed(rd_time_r) >  item_r.time_value;
      TM_BEFORE:    time_ok = $signed(rd_time_r) <  item_r.time_value;
      TM_AT_BEFORE: time_ok = $signed(rd_time_r) <= item_r.time_value;
      default:      time_ok = 1'b0;
    endcase
    unique case (item_r.data_mode)
      DM_IGNORE: data_ok = 1'b1;
      DM_EQUAL:  data_ok = rd_vals_r[0] == item_r.values[0];
      DM_DIFFER: data_ok = rd_vals_r[0] != item_r.values[0];
      default:   data_ok = 1'b0;
    endcase
  end

  assign hit   = rd_valid_r && time_ok && data_ok;
  assign wide  = mask_r[item_r.list_id];
  assign nvals = wide ? WIDE_COUNT : ONE_VALUE;

  always_comb begin
    res_nxt = '0;
    if (list_ok && item_r.operation == OP_APPEND) begin
      res_nxt.list_full = full;
    end
    if (sts.is_query && hit) begin
      res_nxt.found       = 1'b1;
      res_nxt.value_count = nvals;
      res_nxt.match_time  = $signed(rd_time_r);
      for (int j = 0; j < MAX_VALUES; j++) begin
        if (3'(j) < nvals) begin
          res_nxt.values[j] = rd_vals_r[j];
        end
      end
    end
  end

  assign sts.is_query  = list_ok && item_r.operation == OP_QUERY;
  assign sts.is_append = list_ok && item_r.operation == OP_APPEND;
  assign sts.is_clear  = list_ok && item_r.operation == OP_CLEAR;
  assign sts.hit       = hit;
  assign sts.scan_done = issue_done && !rd_valid_r;
  assign res_o         = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r     <= '0;
      rd_valid_r <= 1'b0;
      for (int i = 0; i < NUM_LISTS; i++) begin
        count_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        mask_r <= cfg_data;
      end
      if (do_write) begin
        count_r[lidx] <= cnt_cur + CNT_W'(1);
      end else if (cmd.clear && list_ok) begin
        count_r[lidx] <= '0;
      end
      if (cmd.scan_start) begin
        rd_valid_r <= 1'b0;
      end else begin
        rd_valid_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= item_i;
    end
    if (cmd.scan_start) begin
      n_r    <= cnt_cur;
      step_r <= '0;
    end else if (issue) begin
      step_r <= step_r + CNT_W'(1);
    end
    if (cmd.load_out) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      time_mem[wr_addr] <= item_r.time_value;
    end else begin
      rd_time_r <= time_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      val_mem[wr_addr] <= wr_row;
    end else begin
      rd_vals_r <= val_mem[rd_addr];
    end
  end

endmodule

// ===== rtl/tets_ctrl.sv =====
module tets_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tets_pkg::sts_t sts,
  output tets_pkg::cmd_t cmd
);
  import tets_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        // The result register must be empty before work starts, so the
        // finished result can always be written when it is ready.
        if (!out_valid_r) begin
          if (sts.is_query) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            cmd.append    = sts.is_append;
            cmd.clear     = sts.is_clear;
            cmd.load_out  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.hit || sts.scan_done) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
